### sv/ct2d_pkg.sv
// -----------------------------------------------------------------------------
// ct2d_pkg
// Shared types and constants of the 2D collision test pipeline.
// -----------------------------------------------------------------------------
package ct2d_pkg;

   localparam int FUNC_W  = 3;
   localparam int COORD_W = 15;
   localparam int SIZE_W  = 14;
   localparam int PT_W    = 16;
   localparam int SUM_W   = 17;
   localparam int DIFF_W  = 17;
   localparam int RAD_W   = 15;
   localparam int SQ_W    = 30;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_BOX_BOX       = 3'd0,
      FUNC_CIRCLE_CIRCLE = 3'd1,
      FUNC_BOX_CIRCLE    = 3'd2,
      FUNC_BOX_POINT     = 3'd3,
      FUNC_CIRCLE_POINT  = 3'd4
   } func_type;

   typedef logic [FUNC_W-1:0]         func_code_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [SIZE_W-1:0]         size_type;
   typedef logic signed [PT_W-1:0]    point_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic [RAD_W-1:0]          radius_type;
   typedef logic [SQ_W-1:0]           square_type;

   // operands of the squaring stage
   typedef struct packed {
      diff_type   dx;
      diff_type   dy;
      radius_type r;
   } sq_in_type;

   // squared terms out of the squaring stage
   typedef struct packed {
      square_type dx2;
      square_type dy2;
      square_type r2;
   } sq_out_type;

endpackage

### sv/ct2d_req_if.sv
// -----------------------------------------------------------------------------
// ct2d_req_if
// Request channel: operation code and two shapes, valid/ready handshake.
// -----------------------------------------------------------------------------
interface ct2d_req_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   func;
   logic signed [14:0]           a_x;
   logic signed [14:0]           a_y;
   logic [13:0]                  a_w;
   logic [13:0]                  a_h;
   logic signed [14:0]           b_x;
   logic signed [14:0]           b_y;
   logic [13:0]                  b_w;
   logic [13:0]                  b_h;

   modport source (output valid, func, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                   input ready);
   modport sink   (input valid, func, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                   output ready);
endinterface

### sv/ct2d_rsp_if.sv
// -----------------------------------------------------------------------------
// ct2d_rsp_if
// Response channel: hit flag and contact point, valid/ready handshake.
// -----------------------------------------------------------------------------
interface ct2d_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [15:0] hit_x;
   logic signed [15:0] hit_y;

   modport source (output valid, hit, hit_x, hit_y, input ready);
   modport sink   (input valid, hit, hit_x, hit_y, output ready);
endinterface

### sv/collision_test_2d_unit.sv
// -----------------------------------------------------------------------------
// collision_test_2d_unit
// Four-stage pipelined 2D overlap tester for boxes, circles and points.
// -----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per handshake: an operation code (box-box,
//   circle-circle, box-circle, box-point, circle-point) and two shapes in
//   signed Q.4 coordinates. rsp_ch returns exactly one response per request,
//   in order: a hit flag and the contact point, zero when nothing touches.
//   Unused operation codes return a miss.
// Stages: edge sums, compare/clamp, squaring, final compare into the output
//   register; each is registered, and a request crosses all of them in order
//   before its response is valid.
// Throughput: one request per cycle. Every stage holds one request and the
//   whole pipe advances together, so a request enters each cycle that the
//   output register is empty or being drained.
// Stall: while the response waits and rsp_ch.ready is low, every stage holds
//   and req_ch.ready drops; nothing is lost or repeated.
// Reset: synchronous, clears the stage valid bits only; the pipe is empty
//   and ready on the first cycle after reset.
// -----------------------------------------------------------------------------
module collision_test_2d_unit (
   input  logic clock,
   input  logic reset,
   ct2d_req_if.sink   req_ch,
   ct2d_rsp_if.source rsp_ch
);
   import ct2d_pkg::*;

   // stage 1: far edges, effective radius
   typedef struct packed {
      func_code_type func;
      coord_type     ax;
      coord_type     ay;
      coord_type     bx;
      coord_type     by;
      point_type     aex;
      point_type     aey;
      point_type     bex;
      point_type     bey;
      radius_type    r;
   } s1_type;

   // stage 2: overlap flag, contact candidate, distance terms
   typedef struct packed {
      func_code_type func;
      logic          ov;
      point_type     pt_x;
      point_type     pt_y;
   } s2_type;

   logic       en;
   logic       s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   s1_type     s1_ff, s1_in;
   s2_type     s2_ff, s2_in;
   s2_type     s3_ff;
   sq_in_type  sq_in_ff, sq_in_in;
   sq_out_type sq_out;

   logic       hit_ff, hit_in;
   point_type  hit_x_ff, hit_x_in;
   point_type  hit_y_ff, hit_y_in;

   // advance the whole pipe unless a response sits unaccepted
   assign en           = !s4_v_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // ---------------- stage 1: edge sums --------------------------------------
   always_comb begin
      s1_in.func = req_ch.func;
      s1_in.ax   = req_ch.a_x;
      s1_in.ay   = req_ch.a_y;
      s1_in.bx   = req_ch.b_x;
      s1_in.by   = req_ch.b_y;
      s1_in.aex  = PT_W'(req_ch.a_x) + PT_W'({2'b00, req_ch.a_w});
      s1_in.aey  = PT_W'(req_ch.a_y) + PT_W'({2'b00, req_ch.a_h});
      // a point is a box of zero size
      if (req_ch.func == FUNC_BOX_POINT) begin
         s1_in.bex = PT_W'(req_ch.b_x);
         s1_in.bey = PT_W'(req_ch.b_y);
      end else begin
         s1_in.bex = PT_W'(req_ch.b_x) + PT_W'({2'b00, req_ch.b_w});
         s1_in.bey = PT_W'(req_ch.b_y) + PT_W'({2'b00, req_ch.b_h});
      end
      // radius bound on the center distance
      case (req_ch.func)
         FUNC_CIRCLE_CIRCLE: s1_in.r = RAD_W'(req_ch.a_w) + RAD_W'(req_ch.b_w);
         FUNC_BOX_CIRCLE:    s1_in.r = RAD_W'(req_ch.b_w);
         default:            s1_in.r = RAD_W'(req_ch.a_w);
      endcase
   end

   // ---------------- stage 2: overlap, clamp, differences -------------------
   point_type         ax16, ay16, bx16, by16;
   point_type         lo_x, lo_y, hi_x, hi_y;
   point_type         cx, cy;
   diff_type          cdx, cdy;
   logic signed [SUM_W-1:0] sum_x, sum_y;

   always_comb begin
      ax16 = PT_W'(s1_ff.ax);
      ay16 = PT_W'(s1_ff.ay);
      bx16 = PT_W'(s1_ff.bx);
      by16 = PT_W'(s1_ff.by);

      lo_x = (ax16 > bx16) ? ax16 : bx16;
      lo_y = (ay16 > by16) ? ay16 : by16;
      hi_x = (s1_ff.aex < s1_ff.bex) ? s1_ff.aex : s1_ff.bex;
      hi_y = (s1_ff.aey < s1_ff.bey) ? s1_ff.aey : s1_ff.bey;

      // clamp the circle center into the box, and its offset from there
      if (bx16 < ax16) begin
         cx  = ax16;
         cdx = DIFF_W'(bx16) - DIFF_W'(ax16);
      end else if (bx16 > s1_ff.aex) begin
         cx  = s1_ff.aex;
         cdx = DIFF_W'(bx16) - DIFF_W'(s1_ff.aex);
      end else begin
         cx  = bx16;
         cdx = '0;
      end
      if (by16 < ay16) begin
         cy  = ay16;
         cdy = DIFF_W'(by16) - DIFF_W'(ay16);
      end else if (by16 > s1_ff.aey) begin
         cy  = s1_ff.aey;
         cdy = DIFF_W'(by16) - DIFF_W'(s1_ff.aey);
      end else begin
         cy  = by16;
         cdy = '0;
      end

      if (s1_ff.func == FUNC_BOX_BOX) begin
         sum_x = SUM_W'(lo_x) + SUM_W'(hi_x);
         sum_y = SUM_W'(lo_y) + SUM_W'(hi_y);
      end else begin
         sum_x = SUM_W'(ax16) + SUM_W'(bx16);
         sum_y = SUM_W'(ay16) + SUM_W'(by16);
      end

      s2_in.func = s1_ff.func;
      s2_in.ov   = !(s1_ff.aex < bx16 || ax16 > s1_ff.bex ||
                     s1_ff.aey < by16 || ay16 > s1_ff.bey);
      case (s1_ff.func)
         FUNC_BOX_BOX, FUNC_CIRCLE_CIRCLE: begin
            // arithmetic halving rounds toward minus infinity
            s2_in.pt_x = sum_x[SUM_W-1:1];
            s2_in.pt_y = sum_y[SUM_W-1:1];
         end
         FUNC_BOX_CIRCLE: begin
            s2_in.pt_x = cx;
            s2_in.pt_y = cy;
         end
         default: begin
            s2_in.pt_x = bx16;
            s2_in.pt_y = by16;
         end
      endcase

      if (s1_ff.func == FUNC_BOX_CIRCLE) begin
         sq_in_in.dx = cdx;
         sq_in_in.dy = cdy;
      end else begin
         sq_in_in.dx = DIFF_W'(ax16) - DIFF_W'(bx16);
         sq_in_in.dy = DIFF_W'(ay16) - DIFF_W'(by16);
      end
      sq_in_in.r = s1_ff.r;
   end

   // ---------------- stage 3: squares ---------------------------------------
   ct2d_square u_square (
      .clock  (clock),
      .en     (en),
      .sq_in  (sq_in_ff),
      .sq_out (sq_out)
   );

   // ---------------- stage 4: distance compare, output register ------------
   logic [SQ_W:0] d2;

   always_comb begin
      d2 = (SQ_W+1)'(sq_out.dx2) + (SQ_W+1)'(sq_out.dy2);
      case (s3_ff.func)
         FUNC_BOX_BOX, FUNC_BOX_POINT:                       hit_in = s3_ff.ov;
         FUNC_CIRCLE_CIRCLE, FUNC_BOX_CIRCLE, FUNC_CIRCLE_POINT:
            hit_in = (d2 <= (SQ_W+1)'(sq_out.r2));
         default:                                             hit_in = 1'b0;
      endcase
      // drop the contact point on a miss
      hit_x_in = hit_in ? s3_ff.pt_x : '0;
      hit_y_in = hit_in ? s3_ff.pt_y : '0;
   end

   // ---------------- pipeline registers -------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_ch.valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         sq_in_ff <= sq_in_in;
         s3_ff    <= s2_ff;
         hit_ff   <= hit_in;
         hit_x_ff <= hit_x_in;
         hit_y_ff <= hit_y_in;
      end
   end

   assign rsp_ch.valid = s4_v_ff;
   assign rsp_ch.hit   = hit_ff;
   assign rsp_ch.hit_x = hit_x_ff;
   assign rsp_ch.hit_y = hit_y_ff;

`ifndef SYNTHESIS
   // a miss never carries a contact point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff && !hit_ff |-> hit_x_ff == '0 && hit_y_ff == '0)
      else $error("miss with nonzero contact point");

   // unused operation codes never report a hit
   a_bad_func_miss: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && s3_ff.func != FUNC_BOX_BOX && s3_ff.func != FUNC_CIRCLE_CIRCLE &&
      s3_ff.func != FUNC_BOX_CIRCLE && s3_ff.func != FUNC_BOX_POINT &&
      s3_ff.func != FUNC_CIRCLE_POINT |-> !hit_in)
      else $error("hit on unused operation code");

   // a stalled pipe holds its occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> {s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff} ==
              $past({s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff}))
      else $error("pipeline moved while stalled");

   // an advancing pipe shifts valid bits by one stage
   a_advance: assert property (@(posedge clock) disable iff (reset)
      en |=> s4_v_ff == $past(s3_v_ff) && s2_v_ff == $past(s1_v_ff))
      else $error("valid bit lost or repeated");
`endif

endmodule

### sv/ct2d_square.sv
// -----------------------------------------------------------------------------
// ct2d_square
// Registered squaring stage: squares both distance terms and the radius.
// -----------------------------------------------------------------------------
module ct2d_square (
   input  logic                   clock,
   input  logic                   en,
   input  ct2d_pkg::sq_in_type    sq_in,
   output ct2d_pkg::sq_out_type   sq_out
);
   import ct2d_pkg::*;

   logic signed [2*DIFF_W-1:0] px;
   logic signed [2*DIFF_W-1:0] py;
   logic [2*RAD_W-1:0]         pr;
   sq_out_type                 sq_out_ff;
   sq_out_type                 sq_out_in;

   always_comb begin
      px = sq_in.dx * sq_in.dx;
      py = sq_in.dy * sq_in.dy;
      pr = sq_in.r * sq_in.r;
      // squares of the 17-bit differences stay below 2^30
      sq_out_in.dx2 = px[SQ_W-1:0];
      sq_out_in.dy2 = py[SQ_W-1:0];
      sq_out_in.r2  = pr[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_out_ff <= sq_out_in;
      end
   end

   assign sq_out = sq_out_ff;

endmodule
